// ===== rtl/cnrf_pkg.sv =====
// Shared types, codes and saturation helpers for the cubic Newton root finder.
// No dependencies; imported by cnrf_div, the top level and the testbench.
`default_nettype none

package cnrf_pkg;

	localparam int DefMaxIterations = 64;
	localparam int DefFracBits      = 20;

	// Result status codes.
	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_DERIV     = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_CUBIC    = 3'd0;
	localparam logic [2:0] REG_SQUARE   = 3'd1;
	localparam logic [2:0] REG_LINEAR   = 3'd2;
	localparam logic [2:0] REG_CONSTANT = 3'd3;
	localparam logic [2:0] REG_TOL      = 3'd4;

	// Sequencer states; each product state issues one multiplication.
	typedef enum logic [3:0] {
		S_IDLE,
		S_X2,
		S_X3,
		S_AX3,
		S_BX2,
		S_CX,
		S_DA,
		S_DB,
		S_DC,
		S_CHK,
		S_DIV,
		S_UPD,
		S_OUT
	} seq_state_t;

	// Status of the divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cnrf_mul.sv =====
// Shared signed 32 by 32 multiplier with a registered product.
// Depends on nothing but the clock.
`default_nettype none

module cnrf_mul (
	input  wire logic               clk,
	input  wire logic signed [31:0] op_a,
	input  wire logic signed [31:0] op_b,
	output logic signed [63:0]      product
);

	logic signed [63:0] product_q;

	// One product per cycle, available in the next cycle.
	always_ff @(posedge clk) begin
		product_q <= op_a * op_b;
	end

	assign product = product_q;

endmodule

`default_nettype wire

// ===== rtl/cnrf_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
// Depends on cnrf_pkg for the status struct.
`default_nettype none

module cnrf_div #(
	parameter int FRAC_BITS = cnrf_pkg::DefFracBits
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [31+FRAC_BITS:0] num_mag,
	input  wire logic [31:0]           den_mag,
	output logic [31+FRAC_BITS:0]      quo_mag,
	output cnrf_pkg::div_stat_t        stat
);
	import cnrf_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [32:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [31:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   rem_sh;
	logic          take;

	// Shift in the next numerator bit and try to subtract the divisor.
	assign rem_sh = {rem_q[31:0], quo_q[NW-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath needs no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den_mag;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign quo_mag   = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/cubic_newton_root_finder_unit.sv =====
// Top level of the cubic Newton root finder: APB registers, sequencer and datapath.
// Depends on cnrf_pkg, cnrf_mul and cnrf_div.
//
// Channel  Direction  Handshake            Words
// in       input      in_valid/in_ready    start_point
// out      output     out_valid/out_ready  root, status, iterations_used
// cfg      input      APB psel/penable     coeff_*, tolerance at 4*index
//
// Each Newton step issues its products on the shared multiplier, checks the
// derivative and then runs the bit-serial divider; an item ends when the
// derivative is too small, on convergence or after MAX_ITERATIONS steps.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register until taken, and a finished item holds until that register
// is free. Reset is asynchronous and loads the register defaults.
`default_nettype none

module cubic_newton_root_finder_unit #(
	parameter int MAX_ITERATIONS = cnrf_pkg::DefMaxIterations,
	parameter int FRAC_BITS      = cnrf_pkg::DefFracBits
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] start_point,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      root,
	output logic [1:0]              status,
	output logic [6:0]              iterations_used,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import cnrf_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int SW = $clog2(MAX_ITERATIONS + 1);
	localparam int EW = (SW > 7) ? SW : 7;

	// Configuration registers.
	logic signed [15:0] coeff_a_q, coeff_b_q, coeff_c_q, coeff_d_q;
	logic [20:0]        tol_q;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= 16'sd0;
			coeff_b_q <= 16'sd0;
			coeff_c_q <= 16'sd1;
			coeff_d_q <= 16'sd0;
			tol_q     <= 21'd1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_CUBIC:    coeff_a_q <= pwdata[15:0];
				REG_SQUARE:   coeff_b_q <= pwdata[15:0];
				REG_LINEAR:   coeff_c_q <= pwdata[15:0];
				REG_CONSTANT: coeff_d_q <= pwdata[15:0];
				REG_TOL:      tol_q     <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_CUBIC:    prdata = 32'(coeff_a_q);
			REG_SQUARE:   prdata = 32'(coeff_b_q);
			REG_LINEAR:   prdata = 32'(coeff_c_q);
			REG_CONSTANT: prdata = 32'(coeff_d_q);
			REG_TOL:      prdata = {11'd0, tol_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Datapath state.
	seq_state_t         state_q, state_n;
	logic signed [31:0] x_q, x2_q, fv_q, dv_q;
	logic signed [31:0] res_root_q;
	logic [1:0]         res_status_q;
	logic [SW-1:0]      steps_q;
	logic               out_valid_q;
	logic signed [31:0] root_q;
	logic [1:0]         status_q;
	logic [6:0]         iters_q;

	// Shared multiplier.
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [31:0] prod_fx, prod_int;

	cnrf_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (prod)
	);

	assign prod_fx  = sat32(prod >>> FRAC_BITS);
	assign prod_int = sat32(prod);

	// Integer coefficients widened for the multiplier, constants scaled.
	logic signed [31:0] a_ext, b_ext, c_ext, a3_ext, b2_ext, d_scaled, c_scaled;
	assign a_ext    = 32'(coeff_a_q);
	assign b_ext    = 32'(coeff_b_q);
	assign c_ext    = 32'(coeff_c_q);
	assign a3_ext   = (a_ext <<< 1) + a_ext;
	assign b2_ext   = b_ext <<< 1;
	assign d_scaled = sat32(64'(coeff_d_q) <<< FRAC_BITS);
	assign c_scaled = sat32(64'(coeff_c_q) <<< FRAC_BITS);

	// Saturating sums.
	logic signed [31:0] fv_add_prod, dv_add_prod, fv_add_d, dv_final;
	assign fv_add_prod = sat32(64'(fv_q) + 64'(prod_int));
	assign dv_add_prod = sat32(64'(dv_q) + 64'(prod_int));
	assign fv_add_d    = sat32(64'(fv_q) + 64'(d_scaled));
	assign dv_final    = sat32(64'(dv_add_prod) + 64'(c_scaled));

	// Derivative check.
	logic [32:0] dv_abs;
	logic        deriv_small;
	assign dv_abs      = dv_q[31] ? (33'd0 - 33'(dv_q)) : 33'(dv_q);
	assign deriv_small = (dv_q == 32'sd0) || (dv_abs < 33'(tol_q));

	// Divider on magnitudes.
	logic [NW-1:0] num_mag, quo_mag;
	logic [31:0]   den_mag;
	logic          div_start;
	logic          q_neg;
	div_stat_t     div_stat;
	logic [32:0]   fv_abs;

	assign fv_abs  = fv_q[31] ? (33'd0 - 33'(fv_q)) : 33'(fv_q);
	assign num_mag = NW'(fv_abs) << FRAC_BITS;
	assign den_mag = dv_abs[31:0];
	assign q_neg   = fv_q[31] ^ dv_q[31];

	cnrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (num_mag),
		.den_mag (den_mag),
		.quo_mag (quo_mag),
		.stat    (div_stat)
	);

	// Signed, saturated quotient and the updated estimate.
	logic signed [31:0] q_sat, xn;
	logic [NW:0]        quo_ext;
	logic signed [33:0] step_raw;
	logic [33:0]        step_abs;
	logic               converged;
	logic [SW-1:0]      steps_inc;
	logic               at_limit;

	assign quo_ext = {1'b0, quo_mag};
	always_comb begin
		if (!q_neg) begin
			q_sat = (quo_ext > (NW+1)'(32'h7fffffff)) ? 32'sh7fffffff : quo_mag[31:0];
		end else begin
			q_sat = (quo_ext > (NW+1)'(33'h080000000)) ? 32'sh80000000
			                                             : (32'd0 - quo_mag[31:0]);
		end
	end

	assign xn        = sat32(64'(x_q) - 64'(q_sat));
	assign step_raw  = 34'(xn) - 34'(x_q);
	assign step_abs  = step_raw[33] ? (34'd0 - step_raw) : step_raw;
	assign converged = step_abs < 34'(tol_q);
	assign steps_inc = steps_q + 1'b1;
	assign at_limit  = steps_inc == SW'(MAX_ITERATIONS);

	// Next-state logic.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_n = S_X2;
			S_X2:    state_n = S_X3;
			S_X3:    state_n = S_AX3;
			S_AX3:   state_n = S_BX2;
			S_BX2:   state_n = S_CX;
			S_CX:    state_n = S_DA;
			S_DA:    state_n = S_DB;
			S_DB:    state_n = S_DC;
			S_DC:    state_n = S_CHK;
			S_CHK:   state_n = deriv_small ? S_OUT : S_DIV;
			S_DIV:   if (div_stat.done) state_n = S_UPD;
			S_UPD:   state_n = (converged || at_limit) ? S_OUT : S_X2;
			S_OUT:   if (!out_valid_q || out_ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// Control outputs: handshake, multiplier operands, divider start.
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_a     = x_q;
		mul_b     = x_q;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_X3: begin
				mul_a = prod_fx;
				mul_b = x_q;
			end
			S_AX3: begin
				mul_a = a_ext;
				mul_b = prod_fx;
			end
			S_BX2: begin
				mul_a = b_ext;
				mul_b = x2_q;
			end
			S_CX: begin
				mul_a = c_ext;
				mul_b = x_q;
			end
			S_DA: begin
				mul_a = a3_ext;
				mul_b = x2_q;
			end
			S_DB: begin
				mul_a = b2_ext;
				mul_b = x_q;
			end
			S_CHK: div_start = !deriv_small;
			default: ;
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && in_valid) begin
				steps_q <= '0;
			end
			if (state_q == S_UPD) begin
				steps_q <= steps_inc;
			end
		end
	end

	// Datapath registers.
	logic [EW-1:0] steps_ext;
	assign steps_ext = EW'(steps_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid) x_q <= start_point;
			S_X3:   x2_q <= prod_fx;
			S_BX2:  fv_q <= prod_int;
			S_CX:   fv_q <= fv_add_prod;
			S_DA:   fv_q <= fv_add_prod;
			S_DB: begin
				fv_q <= fv_add_d;
				dv_q <= prod_int;
			end
			S_DC:   dv_q <= dv_final;
			S_CHK: begin
				res_status_q <= ST_DERIV;
				res_root_q   <= 32'sd0;
			end
			S_UPD: begin
				x_q <= xn;
				if (converged) begin
					res_status_q <= ST_CONVERGED;
					res_root_q   <= xn;
				end else begin
					res_status_q <= ST_LIMIT;
					res_root_q   <= 32'sd0;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					root_q   <= res_root_q;
					status_q <= res_status_q;
					iters_q  <= (steps_ext > EW'(127)) ? 7'd127 : steps_ext[6:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign root            = root_q;
	assign status          = status_q;
	assign iterations_used = iters_q;

`ifndef ASSERT_OFF
	// The divider finishes only while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider done outside of divide state");

	// The step count never passes the iteration bound.
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SW'(MAX_ITERATIONS))
		else $error("step count beyond the iteration bound");

	// Starting the divider moves the sequencer into the divide state.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == S_DIV) && div_stat.busy)
		else $error("divider start without divide state");
`endif

endmodule

`default_nettype wire

// ===== tb/cubic_newton_root_finder_unit_test.sv =====
// Testbench for the cubic Newton root finder: drives start points and APB register writes,
// predicts each result with a fixed-point Newton model and checks it word by word.
// Depends on cnrf_pkg and cubic_newton_root_finder_unit.
`timescale 1ns / 100ps
`default_nettype none

module cubic_newton_root_finder_unit_test;
	import cnrf_pkg::*;

	localparam int MaxIter   = 64;
	localparam int FracBits  = 20;
	localparam int CycleCap  = 10000000;

	typedef struct packed {
		logic signed [31:0] root;
		logic [1:0]         status;
		logic [6:0]         iterations_used;
	} root_result_t;

	// Expected results in order plus the register copy used to predict them.
	class root_scoreboard;
		root_result_t pending[$];
		logic signed [15:0] ca, cb, cc, cd;
		logic [20:0] tol;
		int mismatches;

		function new();
			ca = 0; cb = 0; cc = 1; cd = 0; tol = 1;
			mismatches = 0;
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint fmul(longint p, longint q);
			return sat((p * q) >>> FracBits);
		endfunction

		// Runs the Newton loop for one start point and queues the result.
		function void note_start(logic signed [31:0] x0);
			longint a, b, c, d, t, x, x2, x3, fv, dv, adv, q, xn, st;
			int steps;
			root_result_t r;
			a = ca; b = cb; c = cc; d = cd; t = tol; x = x0;
			steps = 0;
			r.status = ST_LIMIT;
			r.root = 0;
			while (steps < MaxIter) begin
				x2 = fmul(x, x);
				x3 = fmul(x2, x);
				fv = sat(sat(a * x3) + sat(b * x2));
				fv = sat(fv + sat(c * x));
				fv = sat(fv + sat(d <<< FracBits));
				dv = sat(sat(3 * a * x2) + sat(2 * b * x));
				dv = sat(dv + sat(c <<< FracBits));
				adv = dv < 0 ? -dv : dv;
				if (dv == 0 || adv < t) begin
					r.status = ST_DERIV;
					break;
				end
				q = sat((fv <<< FracBits) / dv);
				xn = sat(x - q);
				st = xn - x;
				if (st < 0) st = -st;
				steps++;
				x = xn;
				if (st < t) begin
					r.status = ST_CONVERGED;
					r.root = xn;
					break;
				end
			end
			r.iterations_used = steps > 127 ? 7'd127 : steps[6:0];
			pending.push_back(r);
		endfunction

		function void check_result(root_result_t got);
			root_result_t w;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word: root %0d status %0d iters %0d",
						got.root, got.status, got.iterations_used);
				return;
			end
			w = pending.pop_front();
			if (w !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected root %0d status %0d iters %0d, got %0d %0d %0d",
						w.root, w.status, w.iterations_used,
						got.root, got.status, got.iterations_used);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] start_point, root;
	logic [1:0] status;
	logic [6:0] iterations_used;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	root_scoreboard sb;
	bit quiet_phase;
	bit hold_long;
	longint cycles;

	cubic_newton_root_finder_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .start_point(start_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.root(root), .status(status), .iterations_used(iterations_used),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Cycle limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleCap) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, none in the quiet phase.
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ready <= 0;
				repeat (3000) @(posedge clk);
				hold_long = 0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 11);
				out_ready <= 0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{root, status, iterations_used});
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		paddr <= {idx, 2'b00};
		pwdata <= val;
		pwrite <= 1;
		psel <= 1;
		penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
		case (idx)
			REG_CUBIC:    sb.ca = val[15:0];
			REG_SQUARE:   sb.cb = val[15:0];
			REG_LINEAR:   sb.cc = val[15:0];
			REG_CONSTANT: sb.cd = val[15:0];
			REG_TOL:      sb.tol = val[20:0];
			default: ;
		endcase
	endtask

	task automatic set_cubic(input int a, input int b, input int c, input int d,
			input int t);
		reg_write(REG_CUBIC, a);
		reg_write(REG_SQUARE, b);
		reg_write(REG_LINEAR, c);
		reg_write(REG_CONSTANT, d);
		reg_write(REG_TOL, t);
	endtask

	// Offers one word, with an optional idle burst first; returns on acceptance.
	task automatic send_start(input logic signed [31:0] x0);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1;
		start_point <= x0;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_start(x0);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_start();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
			default: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
		endcase
	endfunction

	initial begin
		int phase;
		sb = new();
		quiet_phase = 0;
		hold_long = 0;
		arst_n = 0;
		in_valid = 0;
		start_point = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset registers: f(x) = x, derivative one.
		send_start(32'sh7fffffff);
		send_start(32'sh80000000);
		send_start(0);
		drain();

		// Directed: x^2 - 2, tolerance at extremes, zero derivative at x = 0.
		set_cubic(0, 1, 0, -2, 1);
		send_start(32'sh00100000);
		send_start(0);
		send_start(32'shfff00000);
		drain();
		reg_write(REG_TOL, 32'h00100000);
		send_start(32'sh00300000);
		drain();
		reg_write(REG_TOL, 0);
		send_start(32'sh00100000);
		drain();
		// Extreme coefficients saturate everything.
		set_cubic(32767, -32768, 32767, -32768, 16);
		send_start(32'sh7fffffff);
		send_start(32'sh80000000);
		send_start(32'sh00000001);
		drain();
		set_cubic(-32768, 32767, -32768, 32767, 32'h001fffff);
		send_start(32'sh00080000);
		send_start(32'sh80000000);
		drain();
		// Register beyond the last index is ignored.
		reg_write(3'd5, 32'hffffffff);
		set_cubic(1, 0, -1, 0, 64);
		send_start(32'sh00200000);
		send_start(32'shffe00000);
		send_start(32'sh00093cd4);
		drain();

		// Random phases with fresh registers.
		for (phase = 0; phase < 16; phase++) begin
			if (phase == 15) quiet_phase = 1;
			case (phase % 4)
				0: set_cubic($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
					$urandom_range(0, 8) - 4, $urandom_range(0, 20) - 10,
					$urandom_range(1, 256));
				1: set_cubic(1, 0, $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
					$urandom_range(1, 4096));
				2: set_cubic($urandom, $urandom, $urandom, $urandom, $urandom);
				default: set_cubic(0, $urandom_range(1, 3), 0, -$urandom_range(1, 9),
					$urandom_range(1, 1048576));
			endcase
			if (phase == 3) hold_long = 1;
			repeat (24) send_start(pick_start());
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

`default_nettype wire
